// ===== sv/q16_mul_div_unit_top_defines.svh =====
// Assertion macros for the top-level RTL file of the multiply / divide unit.
`ifndef Q16_MUL_DIV_UNIT_TOP_DEFINES_SVH
`define Q16_MUL_DIV_UNIT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Q16_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define Q16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/q16md_pkg.sv =====
`default_nettype none
package q16md_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W         = 32;
	localparam int QW        = W + FRAC_BITS;
	localparam int PW        = 2 * W;
	// Input register, one register per quotient bit, output register.
	localparam int LAT       = QW + 2;

	typedef enum logic {
		KIND_MUL = 1'b0,
		KIND_DIV = 1'b1
	} kind_t;

	// Payload carried down the divider pipeline.
	typedef struct packed {
		logic          is_div;
		logic          aneg;
		logic          negq;
		logic          dbz;
		logic [W-1:0]  mb;
		logic [W-1:0]  rem;
		logic [QW-1:0] num;
		logic [W-1:0]  mres;
		logic          movf;
	} pipe_t;

endpackage
`default_nettype wire

// ===== sv/q16md_div_step.sv =====
`default_nettype none
module q16md_div_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  q16md_pkg::pipe_t in_data,
	output logic             out_valid,
	output q16md_pkg::pipe_t out_data
);
	import q16md_pkg::*;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       qbit;
	pipe_t      nxt;

	// One restoring step: bring down the next dividend bit and subtract when it fits.
	always_comb begin
		nxt   = in_data;
		trial = {in_data.rem, in_data.num[QW-1]};
		diff  = trial - {1'b0, in_data.mb};
		qbit  = ~diff[W];
		nxt.rem = qbit ? diff[W-1:0] : trial[W-1:0];
		nxt.num = {in_data.num[QW-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule
`default_nettype wire

// ===== sv/q16_mul_div_unit_top.sv =====
// Channel   | Signals                               | Handshake
// ----------+---------------------------------------+---------------------------------
// item in   | kind, operand_a, operand_b            | taken when start && !busy
// item out  | result, overflow, div_by_zero         | valid for one cycle while done
//
// Every Q16.16 item passes from start to done through the input register, the divider steps and the output register.
// The latency is set by the restoring divider, one register stage per quotient bit;
// multiplies travel down the same pipeline so that results leave in order.
// A new item is taken in every cycle; busy is always low because the pipeline never stalls.
// Reset clears the valid bits only; the payload registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
`include "q16_mul_div_unit_top_defines.svh"
module q16_mul_div_unit_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic signed [q16md_pkg::W-1:0] operand_a,
	input  logic signed [q16md_pkg::W-1:0] operand_b,
	output logic                          done,
	output logic signed [q16md_pkg::W-1:0] result,
	output logic                          overflow,
	output logic                          div_by_zero
);
	import q16md_pkg::*;

	// Input stage: magnitudes for the divider and the full product for the multiplier.
	logic              v_s1;
	logic              is_div_s1;
	logic              aneg_s1;
	logic              bneg_s1;
	logic [W-1:0]      ma_s1;
	logic [W-1:0]      mb_s1;
	logic signed [PW-1:0] prod_s1;

	logic [W-1:0] ma_d;
	logic [W-1:0] mb_d;
	logic signed [PW-1:0] prod_d;

	assign busy = 1'b0;

	// The magnitude of the most negative operand, 2^31, still fits in W unsigned bits.
	assign ma_d = operand_a[W-1] ? (~operand_a + W'(1)) : operand_a;
	assign mb_d = operand_b[W-1] ? (~operand_b + W'(1)) : operand_b;

	// Both signed operands are sign-extended to the full product width by the context.
	assign prod_d = operand_a * operand_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		is_div_s1 <= (kind == KIND_DIV);
		aneg_s1   <= operand_a[W-1];
		bneg_s1   <= operand_b[W-1];
		ma_s1     <= ma_d;
		mb_s1     <= mb_d;
		prod_s1   <= prod_d;
	end

	// Multiply is finished here: the arithmetic shift right keeps bits FRAC_BITS and up,
	// and the value fits when all product bits from the result's sign upward agree.
	logic              vld [0:QW];
	pipe_t             stg [0:QW];
	pipe_t             stg_in;
	logic [PW-1:0]     prod_u;

	assign prod_u = prod_s1;

	always_comb begin
		stg_in.is_div = is_div_s1;
		stg_in.aneg   = aneg_s1;
		stg_in.negq   = aneg_s1 ^ bneg_s1;
		stg_in.dbz    = (mb_s1 == '0);
		stg_in.mb     = mb_s1;
		stg_in.rem    = '0;
		stg_in.num    = {ma_s1, {FRAC_BITS{1'b0}}};
		stg_in.mres   = prod_u[FRAC_BITS +: W];
		stg_in.movf   = ~((&prod_u[PW-1:W-1+FRAC_BITS]) | ~(|prod_u[PW-1:W-1+FRAC_BITS]));
	end
	assign stg[0] = stg_in;
	assign vld[0] = v_s1;

	for (genvar g = 0; g < QW; g++) begin : g_step
		q16md_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[g]),
			.in_data  (stg[g]),
			.out_valid(vld[g+1]),
			.out_data (stg[g+1])
		);
	end

	// Final sign fix, overflow and divide-by-zero selection.
	pipe_t         fin;
	logic [QW-1:0] quo;
	logic [W-1:0]  res_d;
	logic          ovf_d;
	logic          dbz_d;

	assign fin = stg[QW];
	assign quo = fin.num;

	always_comb begin
		dbz_d = 1'b0;
		if (!fin.is_div) begin
			res_d = fin.mres;
			ovf_d = fin.movf;
		end else if (fin.dbz) begin
			res_d = fin.aneg ? W'(1) : '1;
			ovf_d = 1'b0;
			dbz_d = 1'b1;
		end else if (fin.negq) begin
			res_d = ~quo[W-1:0] + W'(1);
			// Exactly -2^31 still fits.
			ovf_d = (|quo[QW-1:W]) | (quo[W-1] & (|quo[W-2:0]));
		end else begin
			res_d = quo[W-1:0];
			ovf_d = |quo[QW-1:W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld[QW];
		end
	end

	always_ff @(posedge clk) begin
		result      <= res_d;
		overflow    <= ovf_d;
		div_by_zero <= dbz_d;
	end

	`Q16_ASSERT_IMPL(a_flags_excl, clk, arst_n, done, !(overflow && div_by_zero))
	`Q16_ASSERT_IMPL(a_dbz_value, clk, arst_n, done && div_by_zero, (result == W'(1)) || (result == '1))
	`Q16_ASSERT_IMPL(a_latency, clk, arst_n, start && !busy, ##(LAT) done)
	`Q16_ASSERT_IMPL(a_no_stray, clk, arst_n, done, $past(start, LAT))

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

// Testbench for the Q16.16 multiply / divide unit.
// A queue of pending items is filled by the stimulus process; a driver block presents
// them to the unit at the falling clock edge with random idle bursts, and a monitor
// block checks every result strobe against the oldest predicted result.
module tb;
	import q16md_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		kind_t            op;
		logic [W-1:0]     a;
		logic [W-1:0]     b;
	} mdu_item_t;

	typedef struct {
		logic [W-1:0] value;
		logic         ovf;
		logic         dbz;
	} mdu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic signed [W-1:0] operand_a = '0;
	logic signed [W-1:0] operand_b = '0;
	logic done;
	logic signed [W-1:0] result;
	logic overflow;
	logic div_by_zero;

	mdu_item_t pending_items[$];
	mdu_res_t  expected_results[$];
	int        mismatches = 0;
	int        idle_left = 0;
	bit        idling_on = 1'b1;
	bit        hold_off = 1'b0;
	bit        stim_done = 1'b0;
	int        quiet_cycles = 0;

	q16_mul_div_unit_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.operand_a(operand_a), .operand_b(operand_b), .done(done), .result(result),
		.overflow(overflow), .div_by_zero(div_by_zero)
	);

	always #6 clk = ~clk;

	// Predicts one result. Multiply takes the exact 64-bit product and shifts it right
	// arithmetically, so it rounds toward minus infinity. Divide works on magnitudes,
	// truncates toward zero and then applies the sign.
	function automatic mdu_res_t predict_q16(mdu_item_t it);
		mdu_res_t r;
		logic signed [PW-1:0] prod;
		logic signed [PW-1:0] shifted;
		logic [PW-1:0] ma;
		logic [PW-1:0] mb;
		logic [PW-1:0] quo;
		logic aneg;
		logic bneg;
		r.dbz = 1'b0;
		if (it.op == KIND_MUL) begin
			prod = PW'($signed(it.a)) * PW'($signed(it.b));
			shifted = prod >>> FRAC_BITS;
			r.value = shifted[W-1:0];
			r.ovf = (shifted > 64'sh7FFF_FFFF) || (shifted < -64'sh8000_0000);
		end else begin
			aneg = it.a[W-1];
			bneg = it.b[W-1];
			ma = aneg ? -PW'($signed(it.a)) : PW'($signed(it.a));
			mb = bneg ? -PW'($signed(it.b)) : PW'($signed(it.b));
			if (mb == 0) begin
				r.value = aneg ? 32'd1 : 32'hFFFF_FFFF;
				r.ovf = 1'b0;
				r.dbz = 1'b1;
			end else begin
				quo = (ma << FRAC_BITS) / mb;
				if (aneg ^ bneg) begin
					r.value = W'(-quo);
					r.ovf = quo > 64'h8000_0000;
				end else begin
					r.value = quo[W-1:0];
					r.ovf = quo > 64'h7FFF_FFFF;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [W-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return 32'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(0, 8) <<< 16);
			4, 5: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_item(kind_t op, logic [W-1:0] a, logic [W-1:0] b);
		mdu_item_t it;
		it.op = op;
		it.a = a;
		it.b = b;
		pending_items.push_back(it);
	endtask

	// Driver: the unit takes an item at a rising edge where start is high and busy low.
	// Start is changed only at the falling edge, once per step.
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(predict_q16('{kind_t'(kind), operand_a, operand_b}));
			if (start && busy) begin
				// The current item has not been taken; keep it on the ports.
			end else if (idle_left > 0) begin
				idle_left--;
				start <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				idle_left = $urandom_range(0, 5);
				start <= 1'b0;
			end else if (!hold_off && pending_items.size() > 0) begin
				mdu_item_t it;
				it = pending_items.pop_front();
				kind <= it.op;
				operand_a <= it.a;
				operand_b <= it.b;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each done strobe is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (done) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result %h at %0t", result, $realtime);
				end else begin
					mdu_res_t e;
					e = expected_results.pop_front();
					if (e.value !== result || e.ovf !== overflow || e.dbz !== div_by_zero) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %h ovf %b dbz %b, got %h ovf %b dbz %b",
								e.value, e.ovf, e.dbz, result, overflow, div_by_zero);
					end
				end
			end
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [W-1:0] edge_vals[6];
		kind_t op;
		int k;
		edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h1};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: corner operands for both operations, divide by zero with
		// either dividend sign, and a quotient of exactly -2^31 that still fits.
		for (int i = 0; i < 6; i++) begin
			queue_item(KIND_MUL, edge_vals[i], edge_vals[(i + 1) % 6]);
			queue_item(KIND_DIV, edge_vals[i], edge_vals[(i + 2) % 6]);
		end
		queue_item(KIND_DIV, 32'h0000_0005, 32'h0);
		queue_item(KIND_DIV, 32'hFFFF_FFFB, 32'h0);
		queue_item(KIND_DIV, 32'h8000_0000, 32'h0001_0000);
		queue_item(KIND_DIV, 32'h8000_0000, 32'hFFFF_0000);
		queue_item(KIND_DIV, 32'h4000_0000, 32'hFFFF_8000);
		queue_item(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
		queue_item(KIND_MUL, 32'h8000_0000, 32'h8000_0000);

		// Wait for everything in flight, then one sender pause until the unit drains.
		wait (pending_items.size() == 0);
		hold_off = 1'b1;
		@(negedge clk);
		wait (expected_results.size() == 0);
		repeat (LAT + 5) @(negedge clk);
		hold_off = 1'b0;

		// Random part; the final stretch runs with no idling.
		k = 0;
		while (k < 950) begin
			op = kind_t'($urandom_range(0, 1));
			queue_item(op, pick_operand(), pick_operand());
			k++;
			if (k == 800) begin
				wait (pending_items.size() == 0);
				idling_on = 1'b0;
			end
		end
		wait (pending_items.size() == 0);
		@(negedge clk);
		@(negedge clk);
		wait (expected_results.size() == 0);
		repeat (LAT + 10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

`default_nettype wire
